// ===== hdl/vssm_pkg.sv =====
// ----------------------------------------------------------------------------
// vssm_pkg
// Shared types and constants of the volume segment sector mapper: transaction
// payloads, segment table entry layout and controller states.
// ----------------------------------------------------------------------------
package vssm_pkg;

  localparam int SectorW      = 48;
  localparam int ExtentW      = 32;
  localparam int ExtSizeW     = 25;
  localparam int EntryIdxW    = 4;
  localparam int SegEntries   = 16;
  localparam int SegAddrW     = (SegEntries > 1) ? $clog2(SegEntries) : 1;
  localparam int ExtSizeReset = 8192;

  // Radix-4 divider: two quotient bits per cycle.
  localparam int DivIters = SectorW / 2;
  localparam int DivCntW  = $clog2(DivIters);

  localparam logic ActTranslate = 1'b0;
  localparam logic ActWrite     = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [SectorW-1:0]   sector;
    logic [EntryIdxW-1:0] entry_index;
    logic                 entry_valid;
    logic [ExtentW-1:0]   seg_start_extent;
    logic [ExtentW-1:0]   seg_extent_count;
    logic [ExtentW-1:0]   seg_pv_start_extent;
    logic [SectorW-1:0]   seg_pv_base_sector;
  } vssm_req_t;

  typedef struct packed {
    logic [SectorW-1:0]   mapped_sector;
    logic                 hit;
    logic [EntryIdxW-1:0] hit_entry;
  } vssm_res_t;

  typedef struct packed {
    logic [ExtentW-1:0] first_extent;
    logic [ExtentW-1:0] length;
    logic [ExtentW-1:0] phys_extent;
    logic [SectorW-1:0] phys_base;
  } seg_entry_t;

  typedef struct packed {
    logic                we;
    logic [SegAddrW-1:0] addr;
    logic                valid;
    seg_entry_t          entry;
  } seg_wr_t;

  typedef struct packed {
    logic                 start;
    logic [SectorW-1:0]   dividend;
    logic [ExtSizeW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [SectorW-1:0]   quotient;
    logic [ExtSizeW-1:0]  remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StSearch,
    StSum,
    StMul,
    StAdd
  } vssm_state_e;

endpackage

// ===== hdl/volume_segment_sector_mapper_core.sv =====
// ----------------------------------------------------------------------------
// volume_segment_sector_mapper_core
// Translates logical sectors to physical sectors through a table of linear
// segments, and loads table entries on request.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. Every
// transaction produces exactly one result, shown on res_o for a single cycle
// while res_valid_o is high; the receiver cannot stall it, so it must take the
// result in that cycle. A table write completes at the accept edge, its result
// (all zero) appears in the next cycle and busy stays low, so writes can follow
// back to back. A translation keeps busy high, and its result appears in the
// first cycle in which busy is low again. It passes the radix-4 divider that
// splits the sector into extent and offset (its iterations, and the cycle in
// which the controller sees it finish), a scan of up to 16 table entries
// through the single registered read port of the segment memory, and the
// add, multiply and final add. A miss is known after all 16 entries are
// checked. The table is marked invalid at reset by per-entry valid flags, so
// no clearing pass is needed. The extent size register may only be written
// while busy is low.
// ----------------------------------------------------------------------------
module volume_segment_sector_mapper_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  vssm_pkg::vssm_req_t               req_i,
  input  logic                              cfg_we_i,
  input  logic [vssm_pkg::ExtSizeW-1:0]     cfg_wdata_i,
  output logic                              res_valid_o,
  output vssm_pkg::vssm_res_t               res_o
);

  // Configuration: sectors per extent. A value of zero acts as one.
  logic [vssm_pkg::ExtSizeW-1:0] ext_size_q;
  logic [vssm_pkg::ExtSizeW-1:0] ext_size_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_size_q <= vssm_pkg::ExtSizeW'(vssm_pkg::ExtSizeReset);
    end else if (cfg_we_i) begin
      ext_size_q <= cfg_wdata_i;
    end
  end

  assign ext_size_eff = (ext_size_q == '0) ? vssm_pkg::ExtSizeW'(1) : ext_size_q;

  vssm_pkg::vssm_state_e state_q, state_d;

  logic accept;
  logic accept_wr;
  logic accept_tr;

  assign busy      = (state_q != vssm_pkg::StIdle);
  assign accept    = start && !busy;
  assign accept_wr = accept && (req_i.action == vssm_pkg::ActWrite);
  assign accept_tr = accept && (req_i.action == vssm_pkg::ActTranslate);

  // Divider splits the sector into extent number and offset.
  vssm_pkg::div_req_t div_req;
  vssm_pkg::div_rsp_t div_rsp;

  assign div_req.start    = accept_tr;
  assign div_req.dividend = req_i.sector;
  assign div_req.divisor  = ext_size_eff;

  vssm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Segment table. Writes land at the accept edge of a write transaction.
  // Entry indexes beyond the table are dropped.
  vssm_pkg::seg_wr_t             seg_wr;
  logic [vssm_pkg::SegAddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic                          seg_rvalid;
  vssm_pkg::seg_entry_t          seg_rdata;

  always_comb begin
    seg_wr.we    = accept_wr && (32'(req_i.entry_index) < vssm_pkg::SegEntries);
    seg_wr.addr  = vssm_pkg::SegAddrW'(req_i.entry_index);
    seg_wr.valid = req_i.entry_valid;
    seg_wr.entry.first_extent = req_i.seg_start_extent;
    seg_wr.entry.length       = req_i.seg_extent_count;
    seg_wr.entry.phys_extent  = req_i.seg_pv_start_extent;
    seg_wr.entry.phys_base    = req_i.seg_pv_base_sector;
  end

  vssm_seg_ram u_seg_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (seg_wr),
    .raddr_i  (rd_ptr_q),
    .rvalid_o (seg_rvalid),
    .rdata_o  (seg_rdata)
  );

  // Scan pipeline: the read for entry k is issued while entry k-1 is checked.
  logic                          chk_vld_q, chk_vld_d;
  logic [vssm_pkg::SegAddrW-1:0] chk_idx_q, chk_idx_d;
  logic                          chk_last;
  logic                          seg_match;
  logic [vssm_pkg::SectorW-1:0]  ext_diff;

  assign chk_last = (chk_idx_q == vssm_pkg::SegAddrW'(vssm_pkg::SegEntries - 1));
  assign ext_diff = div_rsp.quotient - vssm_pkg::SectorW'(seg_rdata.first_extent);

  // The extent must lie at or above the segment start and inside its length;
  // the quotient is compared at full width, so extents beyond 32 bits do not wrap.
  assign seg_match = chk_vld_q && seg_rvalid &&
                     (div_rsp.quotient >= vssm_pkg::SectorW'(seg_rdata.first_extent)) &&
                     (ext_diff < vssm_pkg::SectorW'(seg_rdata.length));

  // Datapath registers for the matched segment.
  logic [vssm_pkg::ExtentW-1:0]   diff_q, diff_d;
  logic [vssm_pkg::ExtentW-1:0]   pext_q, pext_d;
  logic [vssm_pkg::SectorW-1:0]   base_q, base_d;
  logic [vssm_pkg::EntryIdxW-1:0] hit_idx_q, hit_idx_d;
  logic [vssm_pkg::ExtentW:0]     psum_q, psum_d;
  logic [vssm_pkg::SectorW-1:0]   prod_q, prod_d;
  logic [vssm_pkg::ExtentW+vssm_pkg::ExtSizeW:0] prod_full;

  assign prod_full = psum_q * ext_size_eff;

  logic                res_valid_q, res_valid_d;
  vssm_pkg::vssm_res_t res_q, res_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vssm_pkg::StIdle: begin
        if (accept_tr) begin
          state_d = vssm_pkg::StDiv;
        end
      end
      vssm_pkg::StDiv: begin
        if (div_rsp.done) begin
          state_d = vssm_pkg::StSearch;
        end
      end
      vssm_pkg::StSearch: begin
        if (seg_match) begin
          state_d = vssm_pkg::StSum;
        end else if (chk_vld_q && chk_last) begin
          state_d = vssm_pkg::StIdle;
        end
      end
      vssm_pkg::StSum: state_d = vssm_pkg::StMul;
      vssm_pkg::StMul: state_d = vssm_pkg::StAdd;
      vssm_pkg::StAdd: state_d = vssm_pkg::StIdle;
      default:         state_d = vssm_pkg::StIdle;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    diff_d      = diff_q;
    pext_d      = pext_q;
    base_d      = base_q;
    hit_idx_d   = hit_idx_q;
    psum_d      = psum_q;
    prod_d      = prod_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      vssm_pkg::StIdle: begin
        if (accept_wr) begin
          res_valid_d = 1'b1;
          res_d       = '0;
        end
      end
      vssm_pkg::StDiv: begin
        rd_ptr_d = '0;
      end
      vssm_pkg::StSearch: begin
        rd_ptr_d  = rd_ptr_q + 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = rd_ptr_q;
        if (seg_match) begin
          chk_vld_d = 1'b0;
          diff_d    = ext_diff[vssm_pkg::ExtentW-1:0];
          pext_d    = seg_rdata.phys_extent;
          base_d    = seg_rdata.phys_base;
          hit_idx_d = vssm_pkg::EntryIdxW'(chk_idx_q);
        end else if (chk_vld_q && chk_last) begin
          // No valid segment covers the extent.
          res_valid_d = 1'b1;
          res_d       = '0;
        end
      end
      vssm_pkg::StSum: begin
        psum_d = {1'b0, pext_q} + {1'b0, diff_q};
      end
      vssm_pkg::StMul: begin
        prod_d = prod_full[vssm_pkg::SectorW-1:0];
      end
      vssm_pkg::StAdd: begin
        res_valid_d         = 1'b1;
        res_d.mapped_sector = base_q + prod_q + vssm_pkg::SectorW'(div_rsp.remainder);
        res_d.hit           = 1'b1;
        res_d.hit_entry     = hit_idx_q;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vssm_pkg::StIdle;
      res_valid_q <= 1'b0;
      chk_vld_q   <= 1'b0;
      rd_ptr_q    <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      chk_vld_q   <= chk_vld_d;
      rd_ptr_q    <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    diff_q    <= diff_d;
    pext_q    <= pext_d;
    base_q    <= base_d;
    hit_idx_q <= hit_idx_d;
    psum_q    <= psum_d;
    prod_q    <= prod_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A write transaction is answered in the very next cycle with a miss.
  a_write_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_wr |=> (res_valid_o && !res_o.hit))
    else $error("write transaction not answered in the next cycle");

  // A miss carries a zero sector and a zero entry index.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.hit) |-> (res_o.mapped_sector == '0 && res_o.hit_entry == '0))
    else $error("miss result carries nonzero fields");

  // The divider only finishes while the controller waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == vssm_pkg::StDiv))
    else $error("divider finished outside the divide state");

  // A translation keeps the block busy and gives no result in the next cycle.
  a_translate_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_tr |=> (busy && !res_valid_o))
    else $error("translation did not hold the block busy");

endmodule

// ===== hdl/vssm_div.sv =====
// ----------------------------------------------------------------------------
// vssm_div
// Iterative unsigned divider, sector by extent size, two restoring steps per
// cycle. Results hold until the next start.
// ----------------------------------------------------------------------------
module vssm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vssm_pkg::div_req_t req_i,
  output vssm_pkg::div_rsp_t rsp_o
);

  logic                             run_q, run_d;
  logic                             done_q, done_d;
  logic [vssm_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [vssm_pkg::SectorW-1:0]     work_q, work_d;
  logic [vssm_pkg::ExtSizeW-1:0]    rem_q, rem_d;
  logic [vssm_pkg::ExtSizeW-1:0]    dvs_q, dvs_d;

  always_comb begin
    logic [vssm_pkg::ExtSizeW:0]  r;
    logic [vssm_pkg::SectorW-1:0] w;
    logic [vssm_pkg::ExtSizeW:0]  rr;
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    w      = work_q;
    rr     = {1'b0, rem_q};
    for (int s = 0; s < 2; s++) begin
      r = {rr[vssm_pkg::ExtSizeW-1:0], w[vssm_pkg::SectorW-1]};
      w = {w[vssm_pkg::SectorW-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r    = r - {1'b0, dvs_q};
        w[0] = 1'b1;
      end
      rr = r;
    end
    if (req_i.start) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      work_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (run_q) begin
      work_d = w;
      rem_d  = rr[vssm_pkg::ExtSizeW-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == vssm_pkg::DivCntW'(vssm_pkg::DivIters - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = work_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hdl/vssm_seg_ram.sv =====
// ----------------------------------------------------------------------------
// vssm_seg_ram
// Segment table: one write port, one registered read port, and per-entry
// valid flags that reset clears.
// ----------------------------------------------------------------------------
module vssm_seg_ram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vssm_pkg::seg_wr_t               wr_i,
  input  logic [vssm_pkg::SegAddrW-1:0]   raddr_i,
  output logic                            rvalid_o,
  output vssm_pkg::seg_entry_t            rdata_o
);

  vssm_pkg::seg_entry_t           mem [vssm_pkg::SegEntries];
  logic [vssm_pkg::SegEntries-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    rdata_o <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_o <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= wr_i.valid;
      end
      rvalid_o <= valid_q[raddr_i];
    end
  end

endmodule
